// ----- hw/rtl/ialu_pkg.sv -----
// Shared types and operation codes of the integer ALU with HI and LO.
`default_nettype none
package ialu_pkg;

   localparam int unsigned WordBits = 32;
   localparam int unsigned LuiShift = 16;

   typedef logic [3:0] action_type;

   localparam action_type ActAdd  = 4'd0;
   localparam action_type ActSub  = 4'd1;
   localparam action_type ActAnd  = 4'd2;
   localparam action_type ActOr   = 4'd3;
   localparam action_type ActXor  = 4'd4;
   localparam action_type ActSlt  = 4'd5;
   localparam action_type ActSll  = 4'd6;
   localparam action_type ActSrl  = 4'd7;
   localparam action_type ActLui  = 4'd8;
   localparam action_type ActRotr = 4'd9;
   localparam action_type ActMult = 4'd10;
   localparam action_type ActDiv  = 4'd11;
   localparam action_type ActMfhi = 4'd12;
   localparam action_type ActMflo = 4'd13;

   // operands and direction for the shared 33-bit adder
   typedef struct packed {
      logic [WordBits:0] x;
      logic [WordBits:0] y;
      logic              sub;
   } add_req_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ialu_adder.sv -----
// Shared 33-bit add/subtract unit used by every arithmetic step.
`default_nettype none
module ialu_adder (
   input  wire ialu_pkg::add_req_type        add_req,
   output logic [ialu_pkg::WordBits:0]       sum
);

   logic [ialu_pkg::WordBits:0] y_eff;

   always_comb begin
      y_eff = add_req.sub ? ~add_req.y : add_req.y;
      sum   = add_req.x + y_eff + {{ialu_pkg::WordBits{1'b0}}, add_req.sub};
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ialu_shift.sv -----
// Shift and rotate unit: sll, srl, rotr and lui.
`default_nettype none
module ialu_shift (
   input  wire ialu_pkg::action_type              action,
   input  wire [ialu_pkg::WordBits-1:0]           value,
   input  wire [4:0]                              amount,
   output logic [ialu_pkg::WordBits-1:0]          shifted
);

   logic [2*ialu_pkg::WordBits-1:0] doubled;
   logic [2*ialu_pkg::WordBits-1:0] rot_wide;

   always_comb begin
      doubled  = {value, value};
      rot_wide = doubled >> amount;
      case (action)
         ialu_pkg::ActSll:  shifted = value << amount;
         ialu_pkg::ActSrl:  shifted = value >> amount;
         ialu_pkg::ActLui:  shifted = value << ialu_pkg::LuiShift;
         ialu_pkg::ActRotr: shifted = rot_wide[ialu_pkg::WordBits-1:0];
         default:           shifted = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/integer_alu_with_hi_lo.sv -----
// Top level of the integer ALU with HI/LO: sequencer, registers and result beat.
// A simple operation gives its result beat in the cycle after acceptance. Mult runs 32
// shared-adder steps; div runs ST_NEG_A and ST_NEG_B for the magnitudes, the restoring
// steps of ST_DIV and the sign fix-ups ST_FIX_Q and ST_FIX_R. Throughput: one simple beat
// per cycle while busy is low; busy holds off new beats while a mult or div runs, so the
// next beat may start in the cycle that carries the strobe. The receiver cannot stall the
// result. Reset (synchronous, active high) clears HI, LO, the sequencer and the strobe.
`default_nettype none
module integer_alu_with_hi_lo (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [3:0]         req_action,
   input  wire  signed [31:0] req_operand_a,
   input  wire  signed [31:0] req_operand_b,
   input  wire  [4:0]         req_shift_amount,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result,
   output logic               rsp_write_enable,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero
);

   localparam int unsigned W = ialu_pkg::WordBits;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG_A,
      ST_NEG_B,
      ST_MUL,
      ST_DIV,
      ST_FIX_Q,
      ST_FIX_R
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  count_ff, count_in;
   logic [W-1:0] op_a_ff, op_a_in;
   logic [W-1:0] op_b_ff, op_b_in;
   logic [W:0]   acc_hi_ff, acc_hi_in;
   logic [W-1:0] acc_lo_ff, acc_lo_in;
   logic         neg_a_ff, neg_a_in;
   logic         neg_q_ff, neg_q_in;
   logic [W-1:0] hi_ff, hi_in;
   logic [W-1:0] lo_ff, lo_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_result_ff, rsp_result_in;
   logic         rsp_we_ff, rsp_we_in;
   logic         rsp_ovf_ff, rsp_ovf_in;
   logic         rsp_dz_ff, rsp_dz_in;

   ialu_pkg::add_req_type add_req;
   logic [W:0]   sum;
   logic [W-1:0] shifted;
   logic [W-1:0] in_a;
   logic [W-1:0] in_b;
   logic         accept;
   logic [W:0]   mul_acc;
   logic [W:0]   div_rs;

   assign in_a   = req_operand_a;
   assign in_b   = req_operand_b;
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   ialu_adder u_adder (
      .add_req (add_req),
      .sum     (sum)
   );

   ialu_shift u_shift (
      .action  (req_action),
      .value   (in_b),
      .amount  (req_shift_amount),
      .shifted (shifted)
   );

   // Steer the shared adder by sequencer state
   always_comb begin
      add_req = '{x: '0, y: '0, sub: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            add_req.x   = {in_a[W-1], in_a};
            add_req.y   = {in_b[W-1], in_b};
            add_req.sub = (req_action != ialu_pkg::ActAdd);
         end
         ST_NEG_A: begin
            add_req.y   = {1'b0, op_a_ff};
            add_req.sub = 1'b1;
         end
         ST_NEG_B: begin
            add_req.y   = {1'b0, op_b_ff};
            add_req.sub = 1'b1;
         end
         ST_MUL: begin
            // last multiplier bit carries negative weight
            add_req.x   = acc_hi_ff;
            add_req.y   = {op_a_ff[W-1], op_a_ff};
            add_req.sub = (count_ff == 5'd31);
         end
         ST_DIV: begin
            add_req.x   = {acc_hi_ff[W-1:0], acc_lo_ff[W-1]};
            add_req.y   = {1'b0, op_b_ff};
            add_req.sub = 1'b1;
         end
         ST_FIX_Q: begin
            add_req.y   = {1'b0, acc_lo_ff};
            add_req.sub = 1'b1;
         end
         ST_FIX_R: begin
            add_req.y   = {1'b0, acc_hi_ff[W-1:0]};
            add_req.sub = 1'b1;
         end
         default: add_req = '{x: '0, y: '0, sub: 1'b0};
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_a_in       = op_a_ff;
      op_b_in       = op_b_ff;
      acc_hi_in     = acc_hi_ff;
      acc_lo_in     = acc_lo_ff;
      neg_a_in      = neg_a_ff;
      neg_q_in      = neg_q_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      rsp_we_in     = rsp_we_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_dz_in     = rsp_dz_ff;
      mul_acc       = acc_lo_ff[0] ? sum : acc_hi_ff;
      div_rs        = {acc_hi_ff[W-1:0], acc_lo_ff[W-1]};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_result_in = '0;
               rsp_we_in     = 1'b0;
               rsp_ovf_in    = 1'b0;
               rsp_dz_in     = 1'b0;
               case (req_action)
                  ialu_pkg::ActAdd, ialu_pkg::ActSub: begin
                     rsp_valid_in = 1'b1;
                     // overflow when the 33-bit sum disagrees with its 32-bit sign
                     if (sum[W] != sum[W-1]) begin
                        rsp_ovf_in = 1'b1;
                     end else begin
                        rsp_result_in = sum[W-1:0];
                        rsp_we_in     = 1'b1;
                     end
                  end
                  ialu_pkg::ActAnd: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = in_a & in_b;
                     rsp_we_in     = 1'b1;
                  end
                  ialu_pkg::ActOr: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = in_a | in_b;
                     rsp_we_in     = 1'b1;
                  end
                  ialu_pkg::ActXor: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = in_a ^ in_b;
                     rsp_we_in     = 1'b1;
                  end
                  ialu_pkg::ActSlt: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = {{(W-1){1'b0}}, sum[W]};
                     rsp_we_in     = 1'b1;
                  end
                  ialu_pkg::ActSll, ialu_pkg::ActSrl, ialu_pkg::ActLui,
                  ialu_pkg::ActRotr: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = shifted;
                     rsp_we_in     = 1'b1;
                  end
                  ialu_pkg::ActMult: begin
                     op_a_in   = in_a;
                     acc_hi_in = '0;
                     acc_lo_in = in_b;
                     count_in  = '0;
                     state_in  = ST_MUL;
                  end
                  ialu_pkg::ActDiv: begin
                     if (in_b == '0) begin
                        // leave HI and LO untouched
                        rsp_valid_in = 1'b1;
                        rsp_dz_in    = 1'b1;
                     end else begin
                        op_a_in  = in_a;
                        op_b_in  = in_b;
                        neg_a_in = in_a[W-1];
                        neg_q_in = in_a[W-1] ^ in_b[W-1];
                        state_in = ST_NEG_A;
                     end
                  end
                  ialu_pkg::ActMfhi: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = hi_ff;
                     rsp_we_in     = 1'b1;
                  end
                  ialu_pkg::ActMflo: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = lo_ff;
                     rsp_we_in     = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_NEG_A: begin
            // take the dividend magnitude
            if (neg_a_ff) begin
               op_a_in = sum[W-1:0];
            end
            state_in = ST_NEG_B;
         end
         ST_NEG_B: begin
            // take the divisor magnitude and load the remainder/quotient pair
            if (neg_a_ff ^ neg_q_ff) begin
               op_b_in = sum[W-1:0];
            end
            acc_hi_in = '0;
            acc_lo_in = op_a_ff;
            count_in  = '0;
            state_in  = ST_DIV;
         end
         ST_MUL: begin
            // add the partial product, then shift the pair right arithmetically
            acc_hi_in = {mul_acc[W], mul_acc[W:1]};
            acc_lo_in = {mul_acc[0], acc_lo_ff[W-1:1]};
            count_in  = count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               hi_in         = mul_acc[W:1];
               lo_in         = {mul_acc[0], acc_lo_ff[W-1:1]};
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV: begin
            // restoring step: keep the difference when it did not go negative
            if (!sum[W]) begin
               acc_hi_in = {1'b0, sum[W-1:0]};
            end else begin
               acc_hi_in = {1'b0, div_rs[W-1:0]};
            end
            acc_lo_in = {acc_lo_ff[W-2:0], !sum[W]};
            count_in  = count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               state_in = ST_FIX_Q;
            end
         end
         ST_FIX_Q: begin
            if (neg_q_ff) begin
               acc_lo_in = sum[W-1:0];
            end
            state_in = ST_FIX_R;
         end
         ST_FIX_R: begin
            // remainder takes the sign of the dividend
            hi_in        = neg_a_ff ? sum[W-1:0] : acc_hi_ff[W-1:0];
            lo_in        = acc_lo_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      acc_hi_ff     <= acc_hi_in;
      acc_lo_ff     <= acc_lo_in;
      neg_a_ff      <= neg_a_in;
      neg_q_ff      <= neg_q_in;
      rsp_result_ff <= rsp_result_in;
      rsp_we_ff     <= rsp_we_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_write_enable   = rsp_we_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule
`default_nettype wire
